### sv/mmgn_pkg.sv
// shared types, constants and opcodes of the min-max gray normalizer
package mmgn_pkg;

    localparam int MAX_PIXELS  = 16384;
    localparam int SAMPLE_BITS = 16;
    localparam int GRAY_BITS   = 8;
    localparam int GRAY_FULL   = (1 << GRAY_BITS) - 1;

    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int NUM_W  = SAMPLE_BITS + GRAY_BITS + 1;
    localparam int DEN_W  = SAMPLE_BITS + GRAY_BITS - 1;
    localparam int STEP_W = $clog2(GRAY_BITS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] sample;
    } item_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       last;
        logic       none_left;
        logic       overflow;
    } result_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_EMIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [SAMPLE_BITS-1:0] sample;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_PREP,
        BK_DIV,
        BK_RESULT
    } back_state_t;

endpackage

### sv/mmgn_front.sv
// front end: accepts words, classifies the opcode and queues commands for the back end
module mmgn_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mmgn_pkg::item_t item,
    output logic          full,
    input  logic          cmd_pop,
    output logic          cmd_valid,
    output mmgn_pkg::cmd_t cmd
);
    import mmgn_pkg::*;

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              accept;
    logic              wr_en;
    logic              rd_en;
    cmd_t              new_cmd;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign accept    = push && !full;
    assign rd_en     = cmd_pop && cmd_valid;

    // unused opcode is taken and dropped here
    always_comb
    begin
        new_cmd.sample = SAMPLE_BITS'(item.sample);
        new_cmd.kind   = CMD_LOAD;
        wr_en          = 1'b0;
        case (item.op)
            OP_CLEAR:
            begin
                new_cmd.kind = CMD_CLEAR;
                wr_en        = accept;
            end
            OP_LOAD:
            begin
                new_cmd.kind = CMD_LOAD;
                wr_en        = accept;
            end
            OP_EMIT:
            begin
                new_cmd.kind = CMD_EMIT;
                wr_en        = accept;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### sv/mmgn_div.sv
// radix-2 restoring divider giving a gray-width quotient, one bit per cycle
module mmgn_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mmgn_pkg::NUM_W-1:0]       dividend,
    input  logic [mmgn_pkg::SAMPLE_BITS-1:0] divisor,
    output logic                             done,
    output logic [mmgn_pkg::GRAY_BITS-1:0]   quotient
);
    import mmgn_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     rem_next;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     den_next;
    logic [GRAY_BITS-1:0] quo_reg;
    logic [GRAY_BITS-1:0] quo_next;
    logic                 fits;

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign fits     = (rem_reg >= NUM_W'(den_reg));

    // quotient is known to fit the gray width, so the divisor starts shifted up
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend;
            den_next  = DEN_W'(divisor) << (GRAY_BITS - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - NUM_W'(den_reg);
            end
            quo_next  = {quo_reg[GRAY_BITS-2:0], fits};
            den_next  = den_reg >> 1;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(GRAY_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

endmodule

### sv/mmgn_back.sv
// back end: frame store, min/max tracking, stretch sequencer and result register
module mmgn_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  mmgn_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output mmgn_pkg::result_t result
);
    import mmgn_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [MAX_PIXELS];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       rdpos_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic                   drop_reg;
    logic [SAMPLE_BITS-1:0] diff_reg;
    logic                   zero_reg;
    logic [GRAY_BITS-1:0]   gray_reg;
    logic                   last_reg;
    logic                   none_reg;
    logic                   out_valid_reg;
    result_t                out_word_reg;

    logic                   store_full;
    logic                   nothing_left;
    logic                   slot_free;
    logic [SAMPLE_BITS-1:0] range_w;
    logic [NUM_W-1:0]       num_w;
    logic                   div_start;
    logic                   div_done;
    logic [GRAY_BITS-1:0]   div_quo;
    logic                   do_clear;
    logic                   do_load;
    logic                   do_drop;
    logic                   do_none;
    logic                   do_read;
    logic                   do_diff;
    logic                   do_zero;
    logic                   do_quo;
    logic                   out_load;

    assign store_full   = (count_reg == CNT_W'(MAX_PIXELS));
    assign nothing_left = (rdpos_reg >= count_reg);
    assign slot_free    = !out_valid_reg || pop;
    assign range_w      = max_reg - min_reg;
    // (v - min) * 255 + range - 1, the multiply done as a shift and subtract
    assign num_w        = (NUM_W'(diff_reg) << GRAY_BITS) - NUM_W'(diff_reg)
                        + NUM_W'(range_w) - NUM_W'(1);
    assign empty        = !out_valid_reg;
    assign result       = out_word_reg;

    mmgn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_w),
        .divisor  (range_w),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_EMIT)
                begin
                    state_next = nothing_left ? BK_RESULT : BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_PREP;
            end
            BK_PREP:
            begin
                state_next = zero_reg ? BK_RESULT : BK_DIV;
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_RESULT;
                end
            end
            BK_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        do_clear  = 1'b0;
        do_load   = 1'b0;
        do_drop   = 1'b0;
        do_none   = 1'b0;
        do_read   = 1'b0;
        do_diff   = 1'b0;
        do_zero   = 1'b0;
        div_start = 1'b0;
        do_quo    = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_CLEAR:
                        begin
                            do_clear = 1'b1;
                        end
                        CMD_LOAD:
                        begin
                            do_load = !store_full;
                            do_drop = store_full;
                        end
                        CMD_EMIT:
                        begin
                            do_none = nothing_left;
                            do_read = !nothing_left;
                        end
                        default:
                        begin
                            do_clear = 1'b0;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                do_diff = 1'b1;
            end
            BK_PREP:
            begin
                do_zero   = zero_reg;
                div_start = !zero_reg;
            end
            BK_DIV:
            begin
                do_quo = div_done;
            end
            BK_RESULT:
            begin
                out_load = slot_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // frame store, no reset: only entries below the count are ever read
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            mem[count_reg[ADDR_W-1:0]] <= cmd.sample;
        end
        if (do_read)
        begin
            rd_data_reg <= mem[rdpos_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            last_reg <= ((rdpos_reg + CNT_W'(1)) == count_reg);
            none_reg <= 1'b0;
        end
        else if (do_none)
        begin
            last_reg <= 1'b0;
            none_reg <= 1'b1;
            gray_reg <= '0;
        end
        if (do_diff)
        begin
            diff_reg <= rd_data_reg - min_reg;
            zero_reg <= (max_reg <= min_reg) || (rd_data_reg <= min_reg);
        end
        if (do_zero)
        begin
            gray_reg <= '0;
        end
        else if (do_quo)
        begin
            gray_reg <= div_quo;
        end
        if (out_load)
        begin
            out_word_reg.gray      <= gray_reg;
            out_word_reg.last      <= last_reg;
            out_word_reg.none_left <= none_reg;
            out_word_reg.overflow  <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            rdpos_reg     <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_clear)
            begin
                count_reg <= '0;
                rdpos_reg <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                drop_reg  <= 1'b0;
            end
            if (do_drop)
            begin
                drop_reg <= 1'b1;
            end
            if (do_load)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (cmd.sample < min_reg)
                begin
                    min_reg <= cmd.sample;
                end
                if (cmd.sample > max_reg)
                begin
                    max_reg <= cmd.sample;
                end
            end
            if (do_read)
            begin
                rdpos_reg <= rdpos_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(MAX_PIXELS)) && (rdpos_reg <= count_reg))
        else $error("read position or count out of range");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == BK_DIV))
        else $error("divider finished outside the divide state");

    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.none_left)
            |-> (out_word_reg.gray == '0) && !out_word_reg.last)
        else $error("empty-frame word carries gray or last");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> $stable(out_word_reg))
        else $error("waiting result word changed");

endmodule

### sv/min_max_gray_normalizer.sv
// top level of the min-max contrast stretch to 8-bit gray
//
// input channel (push/full/item): each word carries op and sample. op clear
// starts a new frame, op load appends a sample to the frame store and updates
// the running min and max, op emit returns the next stored sample stretched
// as ceil((v-min)*255/(max-min)); op 3 is taken and dropped.
// result channel (empty/pop/result): one word per emit, oldest first; it is
// presented while empty is low and taken when pop is high.
// a four-entry command queue parts the front (accept, classify) from the
// back (store, divide, result register), so words keep flowing in while an
// emit is in the divider or its result waits for pop.
// clear and load are done in the back end's idle state as it takes the command;
// an emit runs store read, subtract, numerator and divider start, 8 divide
// steps at one quotient bit per cycle, taking the quotient, and result load,
// which waits for a free result register. a sample at the minimum or a flat
// frame skips the divider; nothing left goes from idle to the result load.
// a stalled receiver holds the result register, the back end waits with its
// next result, and full rises once the command queue fills.
// reset empties the queue and result register and clears count, read
// position, min (to all ones), max and the overflow flag; no clearing pass.
module min_max_gray_normalizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mmgn_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output mmgn_pkg::result_t result
);
    import mmgn_pkg::*;

    // command path between front and back
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    mmgn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    mmgn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### tb/min_max_gray_normalizer_tb.sv
// testbench for the min-max gray normalizer: directed and random words against a scoreboard
module min_max_gray_normalizer_tb;
    import mmgn_pkg::*;

    // op code that the block takes and drops
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_WORDS   = 800;
    localparam int CALM_WORDS     = 100;   // last stretch of the random part runs without gaps
    localparam int PRESSURE_AT    = 300;   // random words sent before the long receiver hold
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 50;
    // no-acceptance stretch that ends the run: the long hold plus an emit, many times over
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_CAP     = 100;

    // scoreboard: mirrors the frame store and the running min/max, queues gray words due
    class contrast_tracker;
        logic [15:0]  pix_mem [MAX_PIXELS];
        int unsigned  n_stored;
        int unsigned  rd_ptr;
        logic [15:0]  lo;
        logic [15:0]  hi;
        bit           dropped;
        result_t      gray_due[$];
        int unsigned  fails;

        function new();
            n_stored = 0;
            rd_ptr   = 0;
            lo       = '1;
            hi       = '0;
            dropped  = 1'b0;
            fails    = 0;
        endfunction

        // ceil((v - lo) * 255 / (hi - lo)) capped at 255, zero for a flat frame or v at or below lo
        function logic [7:0] scale_gray(logic [15:0] v);
            int unsigned span;
            int unsigned num;
            int unsigned q;
            if (hi <= lo || v <= lo)
                return 8'd0;
            span = hi - lo;
            num  = (v - lo) * GRAY_FULL;
            q    = (num + span - 1) / span;
            if (q > GRAY_FULL)
                q = GRAY_FULL;
            return q[7:0];
        endfunction

        function void take_word(item_t w);
            result_t r;
            r = '0;
            case (w.op)
                OP_CLEAR:
                begin
                    n_stored = 0;
                    rd_ptr   = 0;
                    lo       = '1;
                    hi       = '0;
                    dropped  = 1'b0;
                end
                OP_LOAD:
                begin
                    if (n_stored >= MAX_PIXELS)
                        dropped = 1'b1;
                    else
                    begin
                        pix_mem[n_stored] = w.sample;
                        n_stored++;
                        if (w.sample < lo)
                            lo = w.sample;
                        if (w.sample > hi)
                            hi = w.sample;
                    end
                end
                OP_EMIT:
                begin
                    if (rd_ptr >= n_stored)
                        r.none_left = 1'b1;
                    else
                    begin
                        r.gray = scale_gray(pix_mem[rd_ptr]);
                        rd_ptr++;
                        r.last = (rd_ptr == n_stored);
                    end
                    r.overflow = dropped;
                    gray_due.push_back(r);
                end
                default:
                    ;
            endcase
        endfunction

        function void note_miss(string field, int unsigned want, int unsigned got);
            fails++;
            if (fails <= REPORT_CAP)
                $error("%s: expected %0d, actual %0d", field, want, got);
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (gray_due.size() == 0)
            begin
                fails++;
                if (fails <= REPORT_CAP)
                    $error("result word with no emit outstanding: gray %0d", got.gray);
                return;
            end
            want = gray_due.pop_front();
            if (got.gray !== want.gray)
                note_miss("gray", want.gray, got.gray);
            if (got.last !== want.last)
                note_miss("last", want.last, got.last);
            if (got.none_left !== want.none_left)
                note_miss("none_left", want.none_left, got.none_left);
            if (got.overflow !== want.overflow)
                note_miss("overflow", want.overflow, got.overflow);
        endfunction

        function int unsigned pending();
            return gray_due.size();
        endfunction
    endclass

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    full;
    item_t   item  = '0;
    logic    empty;
    logic    pop   = 1'b0;
    result_t result;

    contrast_tracker tracker;

    // handshake counts, watched by the watchdog
    int unsigned words_in    = 0;
    int unsigned words_out   = 0;
    // non-ignored words sent in the random part
    int unsigned random_sent = 0;
    // no idling on either side once set
    bit calm     = 1'b0;
    // asks the receiver for its one long hold
    bit hold_req = 1'b0;

    min_max_gray_normalizer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #2 clk = ~clk;

    // offer one word, maybe after a random gap; push stays high on return so
    // back-to-back words need no second assignment in the same step
    task automatic send_word(input logic [1:0] code, input logic [15:0] value);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{op: code, sample: value};
        @(posedge clk);
        // full is read before the edge takes effect, so this is the edge's handshake
        while (full !== 1'b0)
            @(posedge clk);
        tracker.take_word(item);
        words_in++;
        if (code != OP_NOP)
            random_sent++;
    endtask

    // well-formed frame: clear, loads drawn from a band, then the readout with
    // the odd load slipped in and a few emits past the end
    task automatic run_frame(input int unsigned n_pix, input int unsigned extra);
        logic [15:0] base;
        int unsigned spread;
        int unsigned k;
        base = 16'($urandom);
        case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = $urandom_range(1, 15);
            2:       spread = $urandom_range(16, 4095);
            default: spread = 65535;
        endcase
        send_word(OP_CLEAR, 16'($urandom));
        for (k = 0; k < n_pix; k++)
            send_word(OP_LOAD, 16'(base + $urandom_range(0, spread)));
        for (k = 0; k < n_pix + extra; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_word(OP_LOAD, 16'(base + $urandom_range(0, spread)));
            send_word(OP_EMIT, 16'($urandom));
        end
    endtask

    // stimulus and end of run
    initial
    begin
        tracker = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // emit straight after reset: nothing left
        send_word(OP_EMIT, 16'h0000);
        send_word(OP_NOP, 16'hffff);
        // sample extremes, readout past the end
        send_word(OP_LOAD, 16'h0000);
        send_word(OP_LOAD, 16'hffff);
        send_word(OP_LOAD, 16'h8000);
        send_word(OP_LOAD, 16'h0001);
        repeat (5) send_word(OP_EMIT, 16'hffff);
        // flat frame
        send_word(OP_CLEAR, 16'h5a5a);
        send_word(OP_LOAD, 16'h1234);
        send_word(OP_LOAD, 16'h1234);
        repeat (2) send_word(OP_EMIT, 16'h0000);
        // emit right after a clear
        send_word(OP_CLEAR, 16'h0000);
        send_word(OP_EMIT, 16'h0000);
        // loads during readout widen the range
        send_word(OP_CLEAR, 16'h0000);
        send_word(OP_LOAD, 16'd100);
        send_word(OP_EMIT, 16'h0000);
        send_word(OP_LOAD, 16'd300);
        send_word(OP_LOAD, 16'd200);
        repeat (2) send_word(OP_EMIT, 16'h0000);

        // random part
        random_sent = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            if (random_sent >= RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            if (!hold_req && random_sent >= PRESSURE_AT)
            begin
                // receiver holds off while this frame keeps emits coming
                hold_req = 1'b1;
                run_frame(6, 24);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6:
                        run_frame($urandom_range(1, 12), $urandom_range(0, 2));
                    7:
                        // noise: any op, any sample
                        repeat ($urandom_range(1, 6))
                            send_word(2'($urandom_range(0, 3)), 16'($urandom));
                    8:
                        // broken sequence: loads and emits with no clear
                        repeat ($urandom_range(2, 8))
                            send_word($urandom_range(0, 1) ? OP_LOAD : OP_EMIT,
                                      16'($urandom));
                    default:
                        // ignored words between emits
                        repeat ($urandom_range(1, 4))
                        begin
                            send_word(OP_NOP, 16'($urandom));
                            send_word(OP_EMIT, 16'($urandom));
                        end
                endcase
            end
        end

        push <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.fails == 0)
            $display("min_max_gray_normalizer test passed");
        else
            $display("min_max_gray_normalizer test failed");
        $finish;
    end

    // receiver: checks each taken word, idles in bursts, holds once for a long stretch
    initial
    begin
        int unsigned gap;
        int unsigned hold;
        bit held_once;
        gap       = 0;
        hold      = 0;
        held_once = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && empty === 1'b0)
            begin
                tracker.check_word(result);
                words_out++;
            end
            if (hold != 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if (hold_req && !held_once)
            begin
                held_once = 1'b1;
                hold      = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else if (gap != 0)
            begin
                gap--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 7) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog: too long with no word taken on either side
    initial
    begin
        int unsigned quiet;
        int unsigned seen;
        quiet = 0;
        seen  = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (words_in + words_out != seen)
            begin
                seen  = words_in + words_out;
                quiet = 0;
            end
            else
                quiet++;
        end
        $display("min_max_gray_normalizer test failed");
        $finish;
    end

endmodule
